/* sv/cswht_pkg.sv */
// ============================================================================
// cswht_pkg
// Shared widths, item types and cell payload structs for the sweep core.
// ============================================================================
`default_nettype none

package cswht_pkg;

    localparam int WB  = 32;            // word width of coordinates and result
    localparam int FB  = 16;            // fraction bits
    localparam int OW  = WB + 1;        // offset / relative velocity
    localparam int RW  = WB;            // radius sum
    localparam int PW  = 2 * OW;        // one signed product
    localparam int DW  = PW + 1;        // dot and cross
    localparam int S2W = PW;            // squared speed
    localparam int R2W = 2 * RW;        // squared radius sum
    localparam int CMW = PW;            // cross magnitude
    localparam int H   = CMW / 2;       // half split of s2 and cross magnitude
    localparam int LHW = R2W + S2W;     // R^2 * s2
    localparam int C2W = 2 * CMW;       // cross^2
    localparam int SQN = (LHW + 1) / 2; // root bits, one per sqrt cell
    localparam int NW  = DW + 1;        // dot - root
    localparam int QW  = NW + FB;       // scaled dividend, one bit per div cell

    typedef enum logic [1:0] {
        ST_HIT  = 2'd0,
        ST_ZERO = 2'd1,
        ST_MISS = 2'd2,
        ST_SAT  = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [WB-1:0] mover_x;
        logic signed [WB-1:0] mover_y;
        logic signed [WB-1:0] mover_vx;
        logic signed [WB-1:0] mover_vy;
        logic [WB-2:0]        mover_radius;
        logic signed [WB-1:0] target_x;
        logic signed [WB-1:0] target_y;
        logic signed [WB-1:0] target_vx;
        logic signed [WB-1:0] target_vy;
        logic [WB-2:0]        target_radius;
    } pair_t;

    typedef struct packed {
        logic signed [WB-1:0] contact_time;
        status_t              status;
    } result_t;

    typedef struct packed {
        logic             valid;
        logic             zero;
        logic             miss;
        logic [DW-1:0]    dot;
        logic [S2W-1:0]   s2;
        logic [2*SQN-1:0] rad;
        logic [SQN+1:0]   rem;
        logic [SQN-1:0]   root;
    } sq_t;

    typedef struct packed {
        logic           valid;
        logic           zero;
        logic           miss;
        logic           neg;
        logic [QW-1:0]  num;
        logic [S2W-1:0] rem;
        logic [S2W-1:0] s2;
    } dv_t;

endpackage

`default_nettype wire

/* sv/circle_sweep_hit_time_core.sv */
// ============================================================================
// circle_sweep_hit_time_core
// Time of first contact between a moving circle and a target circle.
// ============================================================================
// Usage:
//   pair channel (pair_valid / pair_ready / pair) carries one circle pair per
//   item: centers and velocities in signed Q16.16, radii in unsigned Q15.16.
//   The result channel (result_valid / result_ready / result) returns
//   contact_time and status for each pair, in order.
//   Throughput is one item per cycle while the row is not frozen: every
//   stage is a register and the square root and divider are rows of
//   cells, one root digit or one quotient bit per cell.
//   The pipe is 6 front stages + SQN (65) root cells + 2 numerator stages
//   + QW (84) divider cells + 1 result register = 158 register stages.
//   The whole row advances together. When result holds a finished item and
//   result_ready is low, the row freezes and pair_ready drops; as soon as
//   the item is taken the row moves again with no bubble.
//   Reset clears all valid bits; no item is in flight afterwards.
// ============================================================================
`default_nettype none

module circle_sweep_hit_time_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pair_valid,
    output logic                    pair_ready,
    input  wire cswht_pkg::pair_t    pair,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output cswht_pkg::result_t      result
);
    import cswht_pkg::*;

    logic en;
    sq_t  sq_chain [0:SQN];
    dv_t  dv_chain [0:QW];

    // advance the whole row unless a finished item is waiting on the receiver
    assign en         = !result_valid || result_ready;
    assign pair_ready = en;

    cswht_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .pair_valid (pair_valid),
        .pair       (pair),
        .sq         (sq_chain[0])
    );

    // square root row: one root bit per cell, most significant first
    for (genvar i = 0; i < SQN; i++)
    begin : g_sqrt
        cswht_sqrt_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .sq_in  (sq_chain[i]),
            .sq_out (sq_chain[i+1])
        );
    end

    // divider row: one quotient bit per cell
    for (genvar j = 0; j < QW; j++)
    begin : g_div
        cswht_div_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .dv_in  (dv_chain[j]),
            .dv_out (dv_chain[j+1])
        );
    end

    cswht_tail u_tail (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .sq_in        (sq_chain[SQN]),
        .dv_first     (dv_chain[0]),
        .dv_last      (dv_chain[QW]),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

/* sv/cswht_front.sv */
// ============================================================================
// cswht_front
// Six-stage front end: offsets, products, dot/cross/speed, wide squares and
// the discriminant with its miss and zero-speed flags.
// ============================================================================
`default_nettype none

module cswht_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            pair_valid,
    input  wire cswht_pkg::pair_t pair,
    output cswht_pkg::sq_t       sq
);
    import cswht_pkg::*;

    logic [4:0] v_reg;
    logic       sq_vld_reg;

    // stage 1
    logic signed [OW-1:0] ox_reg, oy_reg, vx_reg, vy_reg;
    logic [RW-1:0]        rs_reg;
    // stage 2
    logic signed [PW-1:0] pxx_reg, pyy_reg, pxy_reg, pyx_reg, vxx_reg, vyy_reg;
    logic [R2W-1:0]       rr2_reg;
    // stage 3
    logic [DW-1:0]        dot3_reg;
    logic [S2W-1:0]       s23_reg;
    logic [R2W-1:0]       r23_reg;
    logic [CMW-1:0]       cm3_reg;
    // stage 4
    logic [DW-1:0]        dot4_reg;
    logic [S2W-1:0]       s24_reg;
    logic                 z4_reg;
    logic [RW+H-1:0]      pa_reg, pb_reg, pc_reg, pd_reg;
    logic [2*H-1:0]       ca_reg, cb_reg, cc_reg;
    // stage 5
    logic [DW-1:0]        dot5_reg;
    logic [S2W-1:0]       s25_reg;
    logic                 z5_reg;
    logic [LHW-1:0]       lhs_reg;
    logic [C2W-1:0]       c2_reg;
    // stage 6
    sq_t                  sq_reg;

    logic signed [PW-1:0] crs_a, crs_b;
    logic [C2W:0]         diff;

    assign crs_a = pxy_reg;
    assign crs_b = pyx_reg;
    assign diff  = (C2W+1)'(lhs_reg) - (C2W+1)'(c2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg      <= '0;
            sq_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg      <= {v_reg[3:0], pair_valid};
            sq_vld_reg <= v_reg[4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ox_reg  <= OW'(pair.target_x) - OW'(pair.mover_x);
            oy_reg  <= OW'(pair.target_y) - OW'(pair.mover_y);
            vx_reg  <= OW'(pair.mover_vx) - OW'(pair.target_vx);
            vy_reg  <= OW'(pair.mover_vy) - OW'(pair.target_vy);
            rs_reg  <= RW'(pair.mover_radius) + RW'(pair.target_radius);

            pxx_reg <= ox_reg * vx_reg;
            pyy_reg <= oy_reg * vy_reg;
            pxy_reg <= ox_reg * vy_reg;
            pyx_reg <= oy_reg * vx_reg;
            vxx_reg <= vx_reg * vx_reg;
            vyy_reg <= vy_reg * vy_reg;
            rr2_reg <= rs_reg * rs_reg;

            dot3_reg <= $unsigned(DW'(pxx_reg) + DW'(pyy_reg));
            s23_reg  <= $unsigned(vxx_reg) + $unsigned(vyy_reg);
            r23_reg  <= rr2_reg;
            // take the magnitude of the cross product in one compare/subtract
            if (crs_a >= crs_b)
                cm3_reg <= CMW'($unsigned(DW'(crs_a) - DW'(crs_b)));
            else
                cm3_reg <= CMW'($unsigned(DW'(crs_b) - DW'(crs_a)));

            dot4_reg <= dot3_reg;
            s24_reg  <= s23_reg;
            z4_reg   <= (s23_reg == '0);
            pa_reg   <= r23_reg[RW-1:0]   * s23_reg[H-1:0];
            pb_reg   <= r23_reg[RW-1:0]   * s23_reg[S2W-1:H];
            pc_reg   <= r23_reg[R2W-1:RW] * s23_reg[H-1:0];
            pd_reg   <= r23_reg[R2W-1:RW] * s23_reg[S2W-1:H];
            ca_reg   <= cm3_reg[H-1:0]    * cm3_reg[H-1:0];
            cb_reg   <= cm3_reg[H-1:0]    * cm3_reg[CMW-1:H];
            cc_reg   <= cm3_reg[CMW-1:H]  * cm3_reg[CMW-1:H];

            dot5_reg <= dot4_reg;
            s25_reg  <= s24_reg;
            z5_reg   <= z4_reg;
            lhs_reg  <= LHW'(pa_reg) + (LHW'(pb_reg) << H) + (LHW'(pc_reg) << RW)
                      + (LHW'(pd_reg) << (RW + H));
            c2_reg   <= C2W'(ca_reg) + (C2W'(cb_reg) << (H + 1)) + (C2W'(cc_reg) << (2 * H));

            sq_reg.valid <= v_reg[4];
            sq_reg.zero  <= z5_reg;
            sq_reg.miss  <= diff[C2W];
            sq_reg.dot   <= dot5_reg;
            sq_reg.s2    <= s25_reg;
            sq_reg.rad   <= (2*SQN)'(diff[LHW-1:0]);
            sq_reg.rem   <= '0;
            sq_reg.root  <= '0;
        end
    end

    always_comb
    begin
        sq       = sq_reg;
        sq.valid = sq_vld_reg;
    end

endmodule

`default_nettype wire

/* sv/cswht_sqrt_cell.sv */
// ============================================================================
// cswht_sqrt_cell
// One digit of the restoring square root: bring down two bits, try a root bit.
// ============================================================================
`default_nettype none

module cswht_sqrt_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire cswht_pkg::sq_t sq_in,
    output cswht_pkg::sq_t     sq_out
);
    import cswht_pkg::*;

    logic           vld_reg;
    sq_t            sq_reg;
    sq_t            sq_next;
    logic [SQN+3:0] tmp;
    logic [SQN+3:0] trial;
    logic           take;

    assign tmp   = {sq_in.rem, sq_in.rad[2*SQN-1 -: 2]};
    assign trial = (SQN+4)'({sq_in.root, 2'b01});
    assign take  = (tmp >= trial);

    always_comb
    begin
        sq_next      = sq_in;
        sq_next.rad  = sq_in.rad << 2;
        sq_next.rem  = take ? (SQN+2)'(tmp - trial) : (SQN+2)'(tmp);
        sq_next.root = {sq_in.root[SQN-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= sq_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sq_reg <= sq_next;
    end

    always_comb
    begin
        sq_out       = sq_reg;
        sq_out.valid = vld_reg;
    end

endmodule

`default_nettype wire

/* sv/cswht_div_cell.sv */
// ============================================================================
// cswht_div_cell
// One step of restoring division: shift in a dividend bit, shift out a
// quotient bit in its place.
// ============================================================================
`default_nettype none

module cswht_div_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire cswht_pkg::dv_t dv_in,
    output cswht_pkg::dv_t     dv_out
);
    import cswht_pkg::*;

    logic         vld_reg;
    dv_t          dv_reg;
    dv_t          dv_next;
    logic [S2W:0] tmp;
    logic         take;

    assign tmp  = {dv_in.rem, dv_in.num[QW-1]};
    assign take = (tmp >= (S2W+1)'(dv_in.s2));

    always_comb
    begin
        dv_next     = dv_in;
        dv_next.num = {dv_in.num[QW-2:0], take};
        dv_next.rem = take ? S2W'(tmp - (S2W+1)'(dv_in.s2)) : S2W'(tmp);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= dv_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dv_reg <= dv_next;
    end

    always_comb
    begin
        dv_out       = dv_reg;
        dv_out.valid = vld_reg;
    end

endmodule

`default_nettype wire

/* sv/cswht_tail.sv */
// ============================================================================
// cswht_tail
// Numerator and sign ahead of the divider, then floor correction, saturation
// and the result register behind it.
// ============================================================================
`default_nettype none

module cswht_tail (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire cswht_pkg::sq_t     sq_in,
    output cswht_pkg::dv_t         dv_first,
    input  wire cswht_pkg::dv_t     dv_last,
    output logic                   result_valid,
    output cswht_pkg::result_t     result
);
    import cswht_pkg::*;

    logic          v1_reg, v2_reg, rv_reg;
    logic          z1_reg, m1_reg;
    logic [NW-1:0] n1_reg;
    logic [S2W-1:0] s21_reg;
    dv_t           dv_reg;
    result_t       res_reg;
    result_t       res_next;

    logic [QW:0]   q1;
    logic          sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            rv_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= sq_in.valid;
            v2_reg <= v1_reg;
            rv_reg <= dv_last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z1_reg  <= sq_in.zero;
            m1_reg  <= sq_in.miss;
            s21_reg <= sq_in.s2;
            n1_reg  <= $unsigned(NW'($signed(sq_in.dot)) - NW'({1'b0, sq_in.root}));

            dv_reg.valid <= v1_reg;
            dv_reg.zero  <= z1_reg;
            dv_reg.miss  <= m1_reg;
            dv_reg.neg   <= n1_reg[NW-1];
            dv_reg.num   <= {(n1_reg[NW-1] ? (NW'(0) - n1_reg) : n1_reg), {FB{1'b0}}};
            dv_reg.rem   <= '0;
            dv_reg.s2    <= s21_reg;

            res_reg <= res_next;
        end
    end

    always_comb
    begin
        dv_first       = dv_reg;
        dv_first.valid = v2_reg;
    end

    // round toward minus infinity, then clamp to the word range
    assign q1  = (QW+1)'(dv_last.num) + (QW+1)'(dv_last.neg && (dv_last.rem != '0));
    assign sat = dv_last.neg ? ((|q1[QW:WB]) || (q1[WB-1] && (|q1[WB-2:0])))
                             : (|q1[QW:WB-1]);

    always_comb
    begin
        res_next.contact_time = '0;
        res_next.status       = ST_HIT;
        if (dv_last.zero)
            res_next.status = ST_ZERO;
        else if (dv_last.miss)
            res_next.status = ST_MISS;
        else if (sat)
        begin
            res_next.status       = ST_SAT;
            res_next.contact_time = dv_last.neg ? {1'b1, {(WB-1){1'b0}}}
                                                : {1'b0, {(WB-1){1'b1}}};
        end
        else
            res_next.contact_time = dv_last.neg ? $signed(WB'(0) - q1[WB-1:0])
                                                : $signed(q1[WB-1:0]);
    end

    assign result_valid = rv_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

/* tb/circle_sweep_hit_time_core_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// circle_sweep_hit_time_core_tb
// Self-checking bench for the circle sweep contact-time core.
// ============================================================================
// Circle pairs are queued by the initial block and handed to the core by a
// clocked driver. As each pair is accepted, its contact time is worked out
// exactly in wide integer arithmetic and the result is queued. A clocked
// monitor takes results with random stalls and checks them in order.
// ============================================================================

module circle_sweep_hit_time_core_tb;
    import cswht_pkg::*;

    typedef logic signed [255:0] wide_t;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int CALM_TAIL      = 200;  // items at the end sent with no idling
    localparam int LONG_HOLD      = 500;  // receiver hold, well above the pipe depth
    localparam int DRAIN_CYCLES   = 400;
    localparam int PAIR_BITS      = $bits(pair_t);

    logic    clk;
    logic    rst_n;
    logic    pair_valid;
    logic    pair_ready;
    pair_t   pair;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    pair_t   pending_pairs[$];  // waiting to be offered
    result_t expected_hits[$];  // contact times owed by the core
    int      error_count;
    int      results_taken;
    int      idle_cycles;
    bit      long_hold_done;

    circle_sweep_hit_time_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_valid   (pair_valid),
        .pair_ready   (pair_ready),
        .pair         (pair),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // ------------------------------------------------------------------------
    // Exact contact time: ray from the mover center against a circle of the
    // summed radius, floor rounding, saturation to the word range.
    // ------------------------------------------------------------------------
    function automatic result_t predict_contact(pair_t p);
        wide_t   ox, oy, vx, vy, rs, dot, crs, s2, lhs, c2, rest, root, bitv;
        wide_t   num, quo, rmd;
        logic    neg;
        result_t r;
        ox  = wide_t'(p.target_x) - wide_t'(p.mover_x);
        oy  = wide_t'(p.target_y) - wide_t'(p.mover_y);
        vx  = wide_t'(p.mover_vx) - wide_t'(p.target_vx);
        vy  = wide_t'(p.mover_vy) - wide_t'(p.target_vy);
        rs  = wide_t'({1'b0, p.mover_radius}) + wide_t'({1'b0, p.target_radius});
        dot = ox * vx + oy * vy;
        crs = ox * vy - oy * vx;
        s2  = vx * vx + vy * vy;
        r.contact_time = '0;
        if (s2 == 0)
        begin
            r.status = ST_ZERO;
            return r;
        end
        lhs = rs * rs * s2;
        c2  = crs * crs;
        if (c2 > lhs)
        begin
            r.status = ST_MISS;
            return r;
        end
        // floor square root, two bits per step
        rest = lhs - c2;
        root = 0;
        bitv = wide_t'(1) <<< 252;
        while (bitv > rest)
            bitv = bitv >>> 2;
        while (bitv != 0)
        begin
            if (rest >= root + bitv)
            begin
                rest = rest - (root + bitv);
                root = (root >>> 1) + bitv;
            end
            else
                root = root >>> 1;
            bitv = bitv >>> 2;
        end
        num = dot - root;
        neg = num < 0;
        if (neg)
            num = -num;
        num = num <<< FB;
        quo = num / s2;
        rmd = num % s2;
        if (neg && rmd != 0)
            quo = quo + 1;
        if (!neg && quo > wide_t'(32'h7fff_ffff))
        begin
            r.contact_time = 32'h7fff_ffff;
            r.status       = ST_SAT;
        end
        else if (neg && quo > wide_t'(33'h0_8000_0000))
        begin
            r.contact_time = 32'h8000_0000;
            r.status       = ST_SAT;
        end
        else
        begin
            r.contact_time = neg ? -quo[WB-1:0] : quo[WB-1:0];
            r.status       = ST_HIT;
        end
        return r;
    endfunction

    function automatic pair_t make_pair(int mx, int my, int mvx, int mvy, int mr,
                                        int tx, int ty, int tvx, int tvy, int tr);
        pair_t p;
        p.mover_x       = mx;
        p.mover_y       = my;
        p.mover_vx      = mvx;
        p.mover_vy      = mvy;
        p.mover_radius  = mr[WB-2:0];
        p.target_x      = tx;
        p.target_y      = ty;
        p.target_vx     = tvx;
        p.target_vy     = tvy;
        p.target_radius = tr[WB-2:0];
        return p;
    endfunction

    // Signed value spread over +-2^(bits-1).
    function automatic int span(int bits);
        return $signed($urandom) >>> (32 - bits);
    endfunction

    // Mostly scenes near a hit; some full-range noise and pairs with zero relative speed.
    function automatic pair_t random_pair();
        pair_t p;
        int    pick;
        int    sc;
        int    vb;
        pick = $urandom_range(0, 9);
        if (pick < 2)
        begin
            p = pair_t'(PAIR_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom, $urandom, $urandom, $urandom}));
        end
        else
        begin
            sc = $urandom_range(12, 30);
            vb = $urandom_range(4, 30);
            p = make_pair(span(sc), span(sc), span(vb), span(vb),
                          $urandom_range(0, 1 << (sc - 1)),
                          span(sc), span(sc), span(vb), span(vb),
                          $urandom_range(0, 1 << (sc - 1)));
            if (pick == 2)
            begin
                p.target_vx = p.mover_vx;
                p.target_vy = p.mover_vy;
            end
        end
        return p;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: hold each item until accepted, insert random gaps in bursts.
    // Prediction happens at the accepting edge.
    // ------------------------------------------------------------------------
    int gap_left;
    int gap_quiet;

    always @(posedge clk or negedge rst_n)
    begin
        logic  next_valid;
        pair_t next_pair;
        if (!rst_n)
        begin
            pair_valid <= 1'b0;
            pair       <= '0;
            gap_left   = 0;
            gap_quiet  = $urandom_range(0, 40);
        end
        else
        begin
            next_valid = pair_valid;
            next_pair  = pair;
            if (pair_valid && pair_ready)
            begin
                expected_hits.push_back(predict_contact(pair));
                void'(pending_pairs.pop_front());
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                // stretches with no idling alternate with bursts of gaps
                if (gap_left == 0 && gap_quiet == 0 && pending_pairs.size() > CALM_TAIL)
                begin
                    gap_left  = $urandom_range(1, 17);
                    gap_quiet = $urandom_range(0, 60);
                end
                if (gap_left > 0)
                    gap_left--;
                else if (pending_pairs.size() > 0)
                begin
                    if (gap_quiet > 0)
                        gap_quiet--;
                    next_valid = 1'b1;
                    next_pair  = pending_pairs[0];
                end
            end
            pair_valid <= next_valid;
            pair       <= next_pair;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: random stall bursts, one long hold to back the pipe up.
    // ------------------------------------------------------------------------
    int stall_left;
    int stall_quiet;

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        logic    next_ready;
        if (!rst_n)
        begin
            result_ready   <= 1'b0;
            stall_left     = 0;
            stall_quiet    = 0;
            results_taken  = 0;
            long_hold_done = 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                results_taken++;
                if (expected_hits.size() == 0)
                    report_mismatch("unexpected item", result.contact_time, '0);
                else
                begin
                    want = expected_hits.pop_front();
                    if (result.contact_time !== want.contact_time)
                        report_mismatch("contact_time", result.contact_time,
                                        want.contact_time);
                    if (result.status !== want.status)
                        report_mismatch("status", 32'(result.status), 32'(want.status));
                end
                if (results_taken == 300 && !long_hold_done)
                begin
                    stall_left     = LONG_HOLD;
                    long_hold_done = 1'b1;
                end
            end
            if (stall_left == 0 && stall_quiet == 0 && pending_pairs.size() > CALM_TAIL)
            begin
                stall_left  = $urandom_range(1, 17);
                stall_quiet = $urandom_range(0, 60);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                next_ready = 1'b0;
            end
            else
            begin
                if (stall_quiet > 0)
                    stall_quiet--;
                next_ready = 1'b1;
            end
            result_ready <= next_ready;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles in which neither channel moves an item while work is still owed.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && !((pair_valid && pair_ready) || (result_valid && result_ready))
            && (pending_pairs.size() > 0 || expected_hits.size() > 0))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        error_count = 0;
        idle_cycles = 0;
        rst_n       = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // head-on hit, unit radii
        pending_pairs.push_back(make_pair(0, 0, 32'h10000, 0, 32'h10000,
                                          32'ha0000, 0, 0, 0, 32'h10000));
        // zero relative speed: identical velocities
        pending_pairs.push_back(make_pair(5, 7, 32'h30000, -32'h20000, 9,
                                          100, 200, 32'h30000, -32'h20000, 9));
        // miss: passing well clear
        pending_pairs.push_back(make_pair(0, 0, 32'h10000, 0, 32'h10000,
                                          32'ha0000, 32'h100000, 0, 0, 32'h10000));
        // tangent: offset exactly equals the radius sum sideways
        pending_pairs.push_back(make_pair(0, 0, 32'h10000, 0, 32'h10000,
                                          32'ha0000, 32'h20000, 0, 0, 32'h10000));
        // overlap now: negative time
        pending_pairs.push_back(make_pair(0, 0, 32'h10000, 0, 32'h30000,
                                          32'h10000, 0, 0, 0, 32'h30000));
        // contact in the past: moving away
        pending_pairs.push_back(make_pair(0, 0, -32'h10000, 0, 32'h10000,
                                          32'ha0000, 0, 0, 0, 32'h10000));
        // positive saturation: far away, crawling
        pending_pairs.push_back(make_pair(32'h8000_0000, 0, 1, 0, 0,
                                          32'h7fff_ffff, 0, 0, 0, 1));
        // negative saturation: huge overlap, crawling away
        pending_pairs.push_back(make_pair(0, 0, -1, 0, 32'h7fff_ffff,
                                          1, 0, 0, 0, 32'h7fff_ffff));
        // field extremes
        pending_pairs.push_back(make_pair(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                                          32'h7fff_ffff, 32'h7fff_ffff,
                                          32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                                          32'h8000_0000, 32'h7fff_ffff));
        pending_pairs.push_back(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                                          32'h7fff_ffff, 0, 32'h7fff_ffff, 32'h7fff_ffff,
                                          32'h8000_0000, 32'h8000_0000, 0));
        pending_pairs.push_back(make_pair(-1, -1, -1, -1, 32'h7fff_ffff,
                                          -1, -1, -1, -1, 32'h7fff_ffff));
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // zero radii, exact line hit
        pending_pairs.push_back(make_pair(0, 0, 32'h10000, 32'h10000, 0,
                                          32'h50000, 32'h50000, 0, 0, 0));
        // fractional time rounding, both signs
        pending_pairs.push_back(make_pair(0, 0, 3, 0, 1, 10, 0, 0, 0, 1));
        pending_pairs.push_back(make_pair(0, 0, -3, 0, 7, 5, 0, 0, 0, 1));

        // sender pause: let every owed result arrive
        while (pending_pairs.size() > 0 || expected_hits.size() > 0)
            @(posedge clk);

        repeat (1350)
            pending_pairs.push_back(random_pair());

        while (pending_pairs.size() > 0 || expected_hits.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
